/* hdl/ffr_pkg.sv */
package ffr_pkg;

   localparam logic [6:0]  PAYLOAD_MAX = 7'd64;
   localparam logic [7:0]  HEAD_RESET  = 8'ha5;
   localparam logic [7:0]  TAIL_RESET  = 8'h5a;
   localparam logic [6:0]  LEN_RESET   = 7'd16;
   localparam logic [7:0]  PENDING_MAX = 8'hff;
   localparam logic [15:0] ERROR_MAX   = 16'hffff;

   // csr register indexes
   localparam logic [1:0] CSR_HEAD = 2'd0;
   localparam logic [1:0] CSR_TAIL = 2'd1;
   localparam logic [1:0] CSR_LEN  = 2'd2;

   // result kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_REJECT  = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [7:0]  payload_byte;
      logic [5:0]  byte_index;
      logic        last;
      logic [15:0] error_count;
   } ffr_rsp_type;

endpackage

/* hdl/ffr_store.sv */
module ffr_store import ffr_pkg::*; #(
   parameter int BUFFER_DEPTH = 128,
   localparam int AW = $clog2(BUFFER_DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem_ff [BUFFER_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read, so a stalled consumer sees it stable
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/ffr_seq.sv */
module ffr_seq import ffr_pkg::*; #(
   parameter int BUFFER_DEPTH = 128,
   localparam int AW = $clog2(BUFFER_DEPTH)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [7:0]    req_rx_byte,
   input  logic          csr_wr_en,
   input  logic [1:0]    csr_index,
   input  logic [7:0]    csr_wr_data,
   output logic          mem_wr_en,
   output logic [AW-1:0] mem_wr_addr,
   output logic [7:0]    mem_wr_data,
   output logic          mem_rd_en,
   output logic [AW-1:0] mem_rd_addr,
   input  logic [7:0]    mem_rd_data,
   input  logic          out_ready,
   output logic          out_push,
   output ffr_rsp_type   out_rsp
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_SCAN    = 3'd1;
   localparam logic [2:0] S_LAST    = 3'd2;
   localparam logic [2:0] S_REJECT  = 3'd3;
   localparam logic [2:0] S_EMIT_RD = 3'd4;
   localparam logic [2:0] S_EMIT    = 3'd5;

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
      return (p == AW'(BUFFER_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] wp_ff, wp_in;
   logic [AW-1:0] rd_ff, rd_in;
   logic [AW-1:0] scan_addr_ff, scan_addr_in;
   logic [AW-1:0] emit_addr_ff, emit_addr_in;
   logic [7:0]    pending_ff, pending_in;
   logic [15:0]   err_ff, err_in;
   logic [7:0]    head_ff, head_in;
   logic [7:0]    tail_ff, tail_in;
   logic [6:0]    len_ff, len_in;
   logic [7:0]    iss_off_ff, iss_off_in;
   logic [7:0]    dat_off_ff, dat_off_in;
   logic          dat_vld_ff, dat_vld_in;
   logic [7:0]    sum_ff, sum_in;
   logic [7:0]    chk_ff, chk_in;
   logic          head_ok_ff, head_ok_in;
   logic [6:0]    idx_ff, idx_in;

   logic [6:0]    len_eff;
   logic [7:0]    window;
   logic [7:0]    pending_new;
   logic [AW-1:0] rd_new;
   logic          frame_ok;
   logic          emit_last;

   always_comb begin
      if (len_ff == 7'd0) begin
         len_eff = 7'd1;
      end else if (len_ff > PAYLOAD_MAX) begin
         len_eff = PAYLOAD_MAX;
      end else begin
         len_eff = len_ff;
      end
   end

   assign window    = {1'b0, len_eff} + 8'd3;
   assign frame_ok  = head_ok_ff && (sum_ff == chk_ff) && (mem_rd_data == tail_ff);
   assign emit_last = (idx_ff == len_eff - 7'd1);
   assign req_stall = (state_ff != S_IDLE);

   // a saturated pending count means the oldest byte falls out of the window
   assign pending_new = (pending_ff < PENDING_MAX) ? pending_ff + 8'd1 : pending_ff;
   assign rd_new      = (pending_ff < PENDING_MAX) ? rd_ff : wrap_inc(rd_ff);

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      rd_in        = rd_ff;
      scan_addr_in = scan_addr_ff;
      emit_addr_in = emit_addr_ff;
      pending_in   = pending_ff;
      err_in       = err_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      len_in       = len_ff;
      iss_off_in   = iss_off_ff;
      dat_off_in   = dat_off_ff;
      dat_vld_in   = 1'b0;
      sum_in       = sum_ff;
      chk_in       = chk_ff;
      head_ok_in   = head_ok_ff;
      idx_in       = idx_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = wp_ff;
      mem_wr_data  = req_rx_byte;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = scan_addr_ff;
      out_push     = 1'b0;
      out_rsp      = '0;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_HEAD: head_in = csr_wr_data;
            CSR_TAIL: tail_in = csr_wr_data;
            CSR_LEN:  len_in  = csr_wr_data[6:0];
            default: ;
         endcase
      end

      // checksum walk: fold in the byte read in the previous cycle (head match, payload sum, checksum capture)
      if (dat_vld_ff) begin
         if (dat_off_ff == 8'd0) begin
            head_ok_in = (mem_rd_data == head_ff);
         end else if (dat_off_ff <= {1'b0, len_eff}) begin
            sum_in = sum_ff + mem_rd_data;
         end else if (dat_off_ff == {1'b0, len_eff} + 8'd1) begin
            chk_in = mem_rd_data;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               mem_wr_en  = 1'b1;
               wp_in      = wrap_inc(wp_ff);
               pending_in = pending_new;
               rd_in      = rd_new;
               // the scan starts in the next cycle, after the write has landed
               if (pending_new >= window) begin
                  state_in     = S_SCAN;
                  scan_addr_in = rd_new;
                  iss_off_in   = 8'd0;
                  sum_in       = 8'd0;
               end
            end
         end
         S_SCAN: begin
            mem_rd_en    = 1'b1;
            mem_rd_addr  = scan_addr_ff;
            scan_addr_in = wrap_inc(scan_addr_ff);
            iss_off_in   = iss_off_ff + 8'd1;
            dat_vld_in   = 1'b1;
            dat_off_in   = iss_off_ff;
            if (iss_off_ff == window - 8'd1) begin
               state_in = S_LAST;
            end
         end
         S_LAST: begin
            // read data now holds the tail byte
            if (frame_ok) begin
               pending_in   = pending_ff - window;
               rd_in        = scan_addr_ff;
               emit_addr_in = wrap_inc(rd_ff);
               idx_in       = 7'd0;
               state_in     = S_EMIT_RD;
            end else begin
               pending_in = pending_ff - 8'd1;
               rd_in      = wrap_inc(rd_ff);
               if (err_ff != ERROR_MAX) begin
                  err_in = err_ff + 16'd1;
               end
               state_in = S_REJECT;
            end
         end
         S_REJECT: begin
            if (out_ready) begin
               out_push            = 1'b1;
               out_rsp.kind        = KIND_REJECT;
               out_rsp.last        = 1'b1;
               out_rsp.error_count = err_ff;
               state_in            = S_IDLE;
            end
         end
         S_EMIT_RD: begin
            mem_rd_en    = 1'b1;
            mem_rd_addr  = emit_addr_ff;
            emit_addr_in = wrap_inc(emit_addr_ff);
            state_in     = S_EMIT;
         end
         S_EMIT: begin
            if (out_ready) begin
               out_push             = 1'b1;
               out_rsp.kind         = KIND_PAYLOAD;
               out_rsp.payload_byte = mem_rd_data;
               out_rsp.byte_index   = idx_ff[5:0];
               out_rsp.last         = emit_last;
               out_rsp.error_count  = err_ff;
               if (emit_last) begin
                  state_in = S_IDLE;
               end else begin
                  mem_rd_en    = 1'b1;
                  mem_rd_addr  = emit_addr_ff;
                  emit_addr_in = wrap_inc(emit_addr_ff);
                  idx_in       = idx_ff + 7'd1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         wp_ff      <= '0;
         rd_ff      <= '0;
         pending_ff <= 8'd0;
         err_ff     <= 16'd0;
         head_ff    <= HEAD_RESET;
         tail_ff    <= TAIL_RESET;
         len_ff     <= LEN_RESET;
         dat_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         wp_ff      <= wp_in;
         rd_ff      <= rd_in;
         pending_ff <= pending_in;
         err_ff     <= err_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         len_ff     <= len_in;
         dat_vld_ff <= dat_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_addr_ff <= scan_addr_in;
      emit_addr_ff <= emit_addr_in;
      iss_off_ff   <= iss_off_in;
      dat_off_ff   <= dat_off_in;
      sum_ff       <= sum_in;
      chk_ff       <= chk_in;
      head_ok_ff   <= head_ok_in;
      idx_ff       <= idx_in;
   end

endmodule

/* hdl/ffr_out.sv */
module ffr_out import ffr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  ffr_rsp_type rsp_in,
   output logic        ready,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [5:0]  rsp_byte_index,
   output logic        rsp_last,
   output logic [15:0] rsp_error_count
);

   logic        valid_ff, valid_in;
   ffr_rsp_type rsp_ff;

   assign ready    = !valid_ff || !rsp_stall;
   assign valid_in = push || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_kind         = rsp_ff.kind;
   assign rsp_payload_byte = rsp_ff.payload_byte;
   assign rsp_byte_index   = rsp_ff.byte_index;
   assign rsp_last         = rsp_ff.last;
   assign rsp_error_count  = rsp_ff.error_count;

endmodule

/* hdl/fixed_frame_receiver.sv */
// channel   | direction | handshake            | payload
// ----------+-----------+----------------------+--------------------------------------
// req       | in        | req_valid/req_stall  | req_rx_byte
// rsp       | out       | rsp_valid/rsp_stall  | kind, payload_byte, byte_index, last,
//           |           |                      | error_count
// csr       | in        | csr_wr_en            | csr_index, csr_wr_data
//
// An item that completes no window is only written to the byte store. One that does is
// scanned (window = len + 3 bytes) and rejected, or accepted and its payload read out;
// the store has a write and a read port, read one byte a cycle unless rsp_stall holds it.
// req_stall is high from the cycle after an item that completes a window until its last result is
// queued. The last result may wait in the output register while the next item enters.
// Reset is synchronous; the byte store is not cleared and needs no clearing pass.
module fixed_frame_receiver import ffr_pkg::*; #(
   parameter int BUFFER_DEPTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [5:0]  rsp_byte_index,
   output logic        rsp_last,
   output logic [15:0] rsp_error_count,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wr_data
);

   localparam int AW = $clog2(BUFFER_DEPTH);

   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic [7:0]    mem_wr_data;
   logic          mem_rd_en;
   logic [AW-1:0] mem_rd_addr;
   logic [7:0]    mem_rd_data;
   logic          out_ready;
   logic          out_push;
   ffr_rsp_type   out_rsp;

   ffr_store #(
      .BUFFER_DEPTH(BUFFER_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   ffr_seq #(
      .BUFFER_DEPTH(BUFFER_DEPTH)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .out_ready   (out_ready),
      .out_push    (out_push),
      .out_rsp     (out_rsp)
   );

   ffr_out u_out (
      .clock            (clock),
      .reset            (reset),
      .push             (out_push),
      .rsp_in           (out_rsp),
      .ready            (out_ready),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_last         (rsp_last),
      .rsp_error_count  (rsp_error_count)
   );

endmodule

/* hdl/ffr_checker.sv */
module ffr_checker import ffr_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [7:0]  req_rx_byte,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_kind,
   input logic [7:0]  rsp_payload_byte,
   input logic [5:0]  rsp_byte_index,
   input logic        rsp_last,
   input logic [15:0] rsp_error_count,
   input logic        csr_wr_en,
   input logic [1:0]  csr_index,
   input logic [7:0]  csr_wr_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_payload_byte) && $stable(rsp_byte_index)
         && $stable(rsp_last) && $stable(rsp_error_count))
      else $error("rsp item changed while stalled");

   a_reject_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_REJECT) |->
         rsp_last && (rsp_payload_byte == 8'd0) && (rsp_byte_index == 6'd0))
      else $error("rejection item not in its fixed form");

   // payload bytes of one frame follow back to back with rising index
   a_frame_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && (rsp_kind == KIND_PAYLOAD) && !rsp_last |=>
         rsp_valid && (rsp_kind == KIND_PAYLOAD)
         && (rsp_byte_index == $past(rsp_byte_index) + 6'd1)
         && (rsp_error_count == $past(rsp_error_count)))
      else $error("frame payload run broken");

   a_err_monotonic: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(rsp_valid) && !$past(reset) |->
         rsp_error_count >= $past(rsp_error_count))
      else $error("error count went down");

endmodule

bind fixed_frame_receiver ffr_checker u_ffr_checker (.*);
